// ===== rtl/core/khts_pkg.sv =====
// shared types, constants and crc function for the key hash tag node select block
package khts_pkg;

  localparam int KEY_W   = 8;
  localparam int CRC_W   = 16;
  localparam int NODE_W  = 10;
  localparam int CFG_W   = 11;
  localparam int CNT_W   = 5;

  localparam logic [CRC_W-1:0] CRC_POLY    = 16'h1021;
  localparam logic [KEY_W-1:0] OPEN_BRACE  = 8'h7B;
  localparam logic [KEY_W-1:0] CLOSE_BRACE = 8'h7D;
  localparam logic [CFG_W-1:0] NODE_COUNT_RST = 11'd1;

  typedef struct packed {
    logic [KEY_W-1:0] key_byte;
    logic             last_byte;
  } khts_in_t;

  typedef struct packed {
    logic [NODE_W-1:0] node_index;
    logic [CRC_W-1:0]  key_crc;
    logic              tag_used;
  } khts_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_WAIT
  } khts_state_t;

  // crc-16 over one byte, msb first, 0x1021
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [KEY_W-1:0] data);
    logic [CRC_W-1:0] c;
    c = crc ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/khts_mod_unit.sv =====
// bit-serial restoring remainder unit: 16-bit dividend, one bit per cycle
module khts_mod_unit #(
  parameter int DIV_W = 11
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [khts_pkg::CRC_W-1:0]   dividend,
  input  logic [DIV_W-1:0]             divisor,
  output logic                         done,
  output logic [DIV_W-1:0]             rem
);
  import khts_pkg::*;

  logic [CRC_W-1:0] dvd_r, dvd_nxt;
  logic [DIV_W-1:0] div_r, div_nxt;
  logic [DIV_W:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [DIV_W:0]   trial;

  always_comb begin
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r[DIV_W-1:0], dvd_r[CRC_W-1]};
    if (start) begin
      dvd_nxt  = dividend;
      div_nxt  = divisor;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(CRC_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        // partial remainder stays below twice the divisor
        if (trial >= {1'b0, div_r}) begin
          rem_nxt = trial - {1'b0, div_r};
        end else begin
          rem_nxt = trial;
        end
        dvd_nxt = {dvd_r[CRC_W-2:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
      end else begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign done = busy_r && (cnt_r == '0);
  assign rem  = rem_r[DIV_W-1:0];

endmodule

// ===== rtl/core/key_hash_tag_node_select_core.sv =====
// top level: per-byte key crc with hash tag selection and node index by remainder
// Key bytes are taken one per cycle while in_ready is high; each byte updates the
// whole-key CRC-16 and, inside an open tag, the hash tag CRC-16 in the cycle of its
// transfer. A final byte (last_byte set) starts the bit-serial remainder unit, which
// works one bit of the 16-bit CRC per cycle; in_ready stays low after a final byte
// through the remainder steps and the load of the result register. If the previous
// result still waits on out_ready at that point, in_ready stays low until that result
// is taken. The result register lets the next key stream in while a result still
// waits on out_ready.
// node_count 0 acts as 1, and a count above MAX_NODES acts as MAX_NODES.
module key_hash_tag_node_select_core #(
  parameter int MAX_NODES = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  khts_pkg::khts_in_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output khts_pkg::khts_out_t         out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [khts_pkg::CFG_W-1:0]  cfg_node_count
);
  import khts_pkg::*;

  localparam int DIV_W = $clog2(MAX_NODES + 1);

  khts_state_t      state_r, state_nxt;
  logic [CFG_W-1:0] node_count_r;
  logic [CRC_W-1:0] whole_crc_r, tag_crc_r;
  logic             open_seen_r, close_seen_r, tag_closed_r;
  logic [CRC_W-1:0] pend_crc_r;
  logic             pend_tag_r;
  logic             out_valid_r, out_valid_nxt;
  khts_out_t        out_data_r;

  logic [CRC_W-1:0] whole_upd, tag_upd;
  logic             open_upd, close_upd, closed_upd;
  logic             in_xfer, out_free, div_start, div_done, load_out;
  logic [DIV_W-1:0] divisor, div_rem;
  logic [CRC_W-1:0] rem_ext;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  // per-byte tag tracking
  always_comb begin
    whole_upd  = crc_byte(whole_crc_r, in_data.key_byte);
    tag_upd    = tag_crc_r;
    open_upd   = open_seen_r;
    close_upd  = close_seen_r;
    closed_upd = tag_closed_r;
    if (!close_seen_r) begin
      if (in_data.key_byte == CLOSE_BRACE) begin
        close_upd  = 1'b1;
        closed_upd = open_seen_r;
      end else if (open_seen_r) begin
        tag_upd = crc_byte(tag_crc_r, in_data.key_byte);
      end else if (in_data.key_byte == OPEN_BRACE) begin
        open_upd = 1'b1;
      end
    end
  end

  // clamp node count into 1..MAX_NODES
  always_comb begin
    if (node_count_r == '0) begin
      divisor = DIV_W'(1);
    end else if (int'(node_count_r) > MAX_NODES) begin
      divisor = DIV_W'(MAX_NODES);
    end else begin
      divisor = DIV_W'(node_count_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer && in_data.last_byte) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (out_free) begin
            load_out  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign rem_ext = CRC_W'(div_rem);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      node_count_r <= NODE_COUNT_RST;
      whole_crc_r  <= '0;
      tag_crc_r    <= '0;
      open_seen_r  <= 1'b0;
      close_seen_r <= 1'b0;
      tag_closed_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        node_count_r <= cfg_node_count;
      end
      if (in_xfer) begin
        if (in_data.last_byte) begin
          whole_crc_r  <= '0;
          tag_crc_r    <= '0;
          open_seen_r  <= 1'b0;
          close_seen_r <= 1'b0;
          tag_closed_r <= 1'b0;
        end else begin
          whole_crc_r  <= whole_upd;
          tag_crc_r    <= tag_upd;
          open_seen_r  <= open_upd;
          close_seen_r <= close_upd;
          tag_closed_r <= closed_upd;
        end
      end
    end
    if (in_xfer && in_data.last_byte) begin
      pend_crc_r <= closed_upd ? tag_upd : whole_upd;
      pend_tag_r <= closed_upd;
    end
    if (load_out) begin
      out_data_r.node_index <= rem_ext[NODE_W-1:0];
      out_data_r.key_crc    <= pend_crc_r;
      out_data_r.tag_used   <= pend_tag_r;
    end
  end

  // dividend is taken straight from the update path in the transfer cycle
  khts_mod_unit #(
    .DIV_W (DIV_W)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (closed_upd ? tag_upd : whole_upd),
    .divisor  (divisor),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/khts_check.sv =====
// port-level checker for the key hash tag node select core, with its bind
module khts_check (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input khts_pkg::khts_in_t          in_data,
  input logic                        out_valid,
  input logic                        out_ready,
  input khts_pkg::khts_out_t         out_data
);
  import khts_pkg::*;

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a final byte closes the input until its result is formed
  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.last_byte |=> !in_ready)
    else $error("input still open after final byte");

  // a non-final byte never produces a result
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_data.last_byte && !out_valid |=> !out_valid)
    else $error("result without final byte");

  // a new result ends the busy time
  a_rise_ready: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result appeared while still busy");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("bad state after reset");

endmodule

bind key_hash_tag_node_select_core khts_check u_khts_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/key_hash_tag_node_select_core_tb.sv =====
// testbench for the key hash tag node select core: byte stream keys, crc and node index checks
module key_hash_tag_node_select_core_tb;
  import khts_pkg::*;

  localparam int MAX_NODES   = 1024;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_BYTES = 190;
  localparam int SETTLE      = 24;

  typedef enum int {
    SHAPE_RANDOM,
    SHAPE_TAGGED,
    SHAPE_CLOSE_FIRST,
    SHAPE_NESTED,
    SHAPE_UNCLOSED,
    SHAPE_BRACE_SOUP
  } key_shape_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  khts_in_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  khts_out_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_node_count = '0;

  key_hash_tag_node_select_core #(.MAX_NODES(MAX_NODES)) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_node_count (cfg_node_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // stimulus and expectations
  khts_in_t     key_bytes_q[$];
  logic [7:0]   key_build_q[$];
  khts_out_t    slot_expect_q[$];

  // predictor state
  logic [CFG_W-1:0] node_count_cfg = NODE_COUNT_RST;
  logic [15:0]      run_whole_crc = '0;
  logic [15:0]      run_tag_crc = '0;
  logic             run_open_seen = 1'b0;
  logic             run_close_seen = 1'b0;
  logic             run_tag_closed = 1'b0;

  int  error_count = 0;
  int  bytes_queued = 0;
  int  bytes_sent = 0;
  int  keys_checked = 0;
  int  tag_keys_checked = 0;
  int  cycle_count = 0;
  int  in_gap_left = 0;
  int  out_stall_left = 0;
  bit  in_idle_on = 1'b1;
  bit  out_idle_on = 1'b1;

  // bitwise crc-16/xmodem, feeding one data bit at a time
  function automatic logic [15:0] crc16_feed_byte(input logic [15:0] crc, input logic [7:0] d);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ d[i];
      r  = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  task automatic hash_key_byte(input khts_in_t b);
    khts_out_t   slot;
    logic [15:0] chosen;
    int unsigned divisor;
    run_whole_crc = crc16_feed_byte(run_whole_crc, b.key_byte);
    // only the first close brace matters; later braces are plain bytes
    if (!run_close_seen) begin
      if (b.key_byte == CLOSE_BRACE) begin
        run_close_seen = 1'b1;
        run_tag_closed = run_open_seen;
      end else if (run_open_seen) begin
        run_tag_crc = crc16_feed_byte(run_tag_crc, b.key_byte);
      end else if (b.key_byte == OPEN_BRACE) begin
        run_open_seen = 1'b1;
      end
    end
    if (b.last_byte) begin
      chosen  = run_tag_closed ? run_tag_crc : run_whole_crc;
      divisor = node_count_cfg;
      if (divisor == 0) begin
        divisor = 1;
      end else if (divisor > MAX_NODES) begin
        divisor = MAX_NODES;
      end
      slot.node_index = NODE_W'(chosen % divisor);
      slot.key_crc    = chosen;
      slot.tag_used   = run_tag_closed;
      slot_expect_q.insert(slot_expect_q.size(), slot);
      run_whole_crc  = '0;
      run_tag_crc    = '0;
      run_open_seen  = 1'b0;
      run_close_seen = 1'b0;
      run_tag_closed = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (error_count < 40) begin
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    end
    error_count++;
  endtask

  // driver: one key byte per transfer, random gap after each byte while in_idle_on is set
  always @(posedge clk) begin
    logic     busy;
    logic     nxt_valid;
    khts_in_t nxt_data;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      busy      = in_valid;
      nxt_valid = 1'b0;
      nxt_data  = in_data;
      if (in_valid && in_ready) begin
        hash_key_byte(in_data);
        bytes_sent++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (in_gap_left > 0) begin
          in_gap_left--;
        end else if (key_bytes_q.size() != 0) begin
          nxt_data    = key_bytes_q.pop_front();
          nxt_valid   = 1'b1;
          in_gap_left = in_idle_on ? $urandom_range(0, 11) : 0;
        end
        in_valid <= nxt_valid;
        in_data  <= nxt_data;
      end
    end
  end

  // monitor: checks each result transfer against the oldest expectation
  always @(posedge clk) begin
    khts_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (slot_expect_q.size() == 0) begin
          report_mismatch("unexpected result, key_crc", out_data.key_crc, -1);
        end else begin
          want = slot_expect_q.pop_front();
          if (out_data.node_index !== want.node_index)
            report_mismatch("node_index", out_data.node_index, want.node_index);
          if (out_data.key_crc !== want.key_crc)
            report_mismatch("key_crc", out_data.key_crc, want.key_crc);
          if (out_data.tag_used !== want.tag_used)
            report_mismatch("tag_used", out_data.tag_used, want.tag_used);
          keys_checked++;
          if (want.tag_used) begin
            tag_keys_checked++;
          end
        end
        out_stall_left = out_idle_on ? $urandom_range(0, 11) : 0;
      end
      if (out_stall_left > 0) begin
        out_stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               slot_expect_q.size());
      $display("FAIL key_hash_tag_node_select_core");
      $finish;
    end
  end

  task automatic add_byte(input logic [7:0] b);
    key_build_q.insert(key_build_q.size(), b);
  endtask

  task automatic add_filler(input int n);
    repeat (n) add_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic flush_key();
    khts_in_t item;
    foreach (key_build_q[i]) begin
      item.key_byte  = key_build_q[i];
      item.last_byte = (i == key_build_q.size() - 1);
      key_bytes_q.insert(key_bytes_q.size(), item);
      bytes_queued++;
    end
    key_build_q.delete();
  endtask

  task automatic add_random_key();
    key_shape_t shape;
    shape = key_shape_t'($urandom_range(0, 5));
    case (shape)
      SHAPE_RANDOM: add_filler($urandom_range(1, 10));
      SHAPE_TAGGED: begin
        add_filler($urandom_range(0, 4));
        add_byte(OPEN_BRACE);
        add_filler($urandom_range(0, 5));
        add_byte(CLOSE_BRACE);
        add_filler($urandom_range(0, 4));
      end
      SHAPE_CLOSE_FIRST: begin
        add_filler($urandom_range(0, 3));
        add_byte(CLOSE_BRACE);
        add_filler($urandom_range(0, 3));
        add_byte(OPEN_BRACE);
        add_filler($urandom_range(0, 3));
        add_byte(CLOSE_BRACE);
        add_filler($urandom_range(0, 2));
      end
      SHAPE_NESTED: begin
        add_filler($urandom_range(0, 2));
        add_byte(OPEN_BRACE);
        add_filler($urandom_range(0, 3));
        add_byte(OPEN_BRACE);
        add_filler($urandom_range(0, 3));
        add_byte(CLOSE_BRACE);
        add_filler($urandom_range(0, 2));
      end
      SHAPE_UNCLOSED: begin
        add_filler($urandom_range(0, 3));
        add_byte(OPEN_BRACE);
        add_filler($urandom_range(0, 5));
      end
      default: begin
        repeat ($urandom_range(1, 12)) begin
          case ($urandom_range(0, 2))
            0: add_byte(OPEN_BRACE);
            1: add_byte(CLOSE_BRACE);
            default: add_filler(1);
          endcase
        end
      end
    endcase
    flush_key();
  endtask

  // config is only written with nothing in flight: every byte taken, every result seen
  task automatic wait_drained();
    while (bytes_sent != bytes_queued || slot_expect_q.size() != 0 || out_valid) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_node_count(input logic [CFG_W-1:0] value);
    cfg_node_count <= value;
    cfg_valid      <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid      <= 1'b0;
    node_count_cfg = value;
  endtask

  initial begin
    logic [CFG_W-1:0] phase_counts[8];
    int               target;
    phase_counts = '{11'd1024, 11'd0, 11'd2047, 11'd1, 11'd1023, 11'd1025, 11'd2,
                     11'($urandom_range(3, 2047))};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_node_count(11'd1000);

    // directed keys
    add_byte(8'h00); flush_key();
    add_byte(8'hFF); flush_key();
    add_byte(OPEN_BRACE); add_byte(CLOSE_BRACE); flush_key();
    add_byte(CLOSE_BRACE); add_byte(OPEN_BRACE); add_byte("a"); add_byte(CLOSE_BRACE);
    flush_key();
    add_byte(OPEN_BRACE); add_byte("a"); add_byte(OPEN_BRACE); add_byte("b");
    add_byte(CLOSE_BRACE); add_byte("c"); flush_key();
    add_byte("a"); add_byte("b"); add_byte(OPEN_BRACE); add_byte("c"); flush_key();
    add_byte("x"); add_byte(OPEN_BRACE); add_byte(8'hAA); add_byte(8'h55);
    add_byte(CLOSE_BRACE); add_byte("y"); flush_key();
    add_byte(8'hFF); add_byte(8'h80); add_byte(8'h01); flush_key();

    for (int p = 0; p < 8; p++) begin
      wait_drained();
      write_node_count(phase_counts[p]);
      in_idle_on  = (p % 4) inside {0, 1};
      out_idle_on = (p % 4) inside {0, 2};
      target = bytes_queued + PHASE_BYTES;
      while (bytes_queued < target) begin
        add_random_key();
      end
    end
    wait_drained();

    if (slot_expect_q.size() != 0) begin
      report_mismatch("results never delivered", 0, slot_expect_q.size());
    end
    $display("covered %0d key bytes and %0d keys (%0d hashed by tag), nine node count settings",
             bytes_sent, keys_checked, tag_keys_checked);
    $display("node counts included zero, one, the maximum and values above it");
    if (error_count == 0) begin
      $display("PASS key_hash_tag_node_select_core");
    end else begin
      $display("FAIL key_hash_tag_node_select_core");
    end
    $finish;
  end

endmodule
